// File: rtl/spectrum_trace_average_max_hold_defines.svh
// assertion macros for the spectrum trace block, clocked on aclk, off during reset
`ifndef SPECTRUM_TRACE_AVERAGE_MAX_HOLD_DEFINES_SVH
`define SPECTRUM_TRACE_AVERAGE_MAX_HOLD_DEFINES_SVH

// condition must hold at every edge out of reset
`define STAMH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define STAMH_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/stamh_pkg.sv
// types, constants and the log fraction table of the spectrum trace block
`timescale 1ns / 1ps

package stamh_pkg;

    localparam int IDX_W    = 12;
    localparam int VAL_W    = 24;
    localparam int LVL_W    = 16;
    localparam int OFFS_W   = 14;
    localparam int CFG_A_W  = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // register indexes of the configuration port
    localparam logic [CFG_A_W-1:0] REG_START_BIN   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_STOP_BIN    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_LEVEL_OFFS  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_AVG_EN      = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_MAX_HOLD_EN = 3'd4;

    localparam logic [IDX_W-1:0] START_BIN_RST = 12'd0;
    localparam logic [IDX_W-1:0] STOP_BIN_RST  = 12'd2048;

    // round(20*log10(2)*64*256)
    localparam logic [16:0] LOG_SCALE = 17'd98642;
    // weight 0.1 in 1/65536
    localparam logic signed [31:0] AVG_WEIGHT = 32'sd6554;
    localparam logic signed [31:0] AVG_ROUND  = 32'sd32768;

    localparam logic signed [LVL_W-1:0] TRACE_RESET = -16'sd9600;
    localparam logic signed [LVL_W-1:0] LEVEL_MIN   = -16'sd32768;

    localparam int OFIFO_DEPTH = 16;
    localparam int OFIFO_PTR_W = 4;
    localparam int OFIFO_CNT_W = 5;

    typedef struct packed {
        logic signed [LVL_W-1:0] peak_level;
        logic signed [LVL_W-1:0] trace_level;
        logic [IDX_W-1:0]        trace_index;
    } res_t;

    typedef logic [255:0][8:0] flog_tab_t;

    // log2(1+f/256) in 8 fractional bits, found bit by bit by repeated squaring
    function automatic flog_tab_t build_flog_tab();
        flog_tab_t   tab;
        logic [63:0] x;
        logic [15:0] r;
        logic [16:0] rr;
        for (int f = 0; f < 256; f++) begin
            x = 64'(256 + f) << 22;
            r = '0;
            for (int k = 0; k < 16; k++) begin
                x = (x * x) >> 30;
                r = {r[14:0], 1'b0};
                if (x >= 64'h8000_0000) begin
                    x = x >> 1;
                    r[0] = 1'b1;
                end
            end
            rr = 17'(r) + 17'd128;
            tab[f] = rr[16:8];
        end
        return tab;
    endfunction

    localparam flog_tab_t FLOG_TAB = build_flog_tab();

    function automatic logic signed [LVL_W-1:0] sat16(logic signed [16:0] v);
        logic signed [LVL_W-1:0] r;
        if (v > 17'sd32767) r = 16'sd32767;
        else if (v < -17'sd32768) r = LEVEL_MIN;
        else r = v[LVL_W-1:0];
        return r;
    endfunction

endpackage

// File: rtl/spectrum_trace_average_max_hold.sv
// log-power trace with video averaging and max hold over trace and peak memories
// a result passes the level pipeline, the memory update and the output queue
// throughput: one bin per cycle while s_tready is high, set by the memory
//   read-modify-write of trace and peak with a bypass of the previous write
// reset: synchronous; control clears at once, then a clearing pass writes the
//   store reset values to all min(FFT_BINS, 4096) entries while s_tready is low
`timescale 1ns / 1ps
`include "spectrum_trace_average_max_hold_defines.svh"

module spectrum_trace_average_max_hold
    import stamh_pkg::*;
#(
    parameter int FFT_BINS = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [OFFS_W-1:0]    cfg_wdata,
    // input bins
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // bin_index[11:0], bin_value[35:12]
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // trace_index[11:0], trace_level[27:12],
                                            // peak_level[43:28]
);

    localparam int DEPTH  = (FFT_BINS < 4096) ? FFT_BINS : 4096;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration
    logic [IDX_W-1:0]         start_bin_reg;
    logic [IDX_W-1:0]         stop_bin_reg;
    logic signed [OFFS_W-1:0] level_offset_reg;
    logic                     avg_en_reg;
    logic                     max_hold_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_bin_reg    <= START_BIN_RST;
            stop_bin_reg     <= STOP_BIN_RST;
            level_offset_reg <= '0;
            avg_en_reg       <= 1'b1;
            max_hold_en_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START_BIN:   start_bin_reg    <= cfg_wdata[IDX_W-1:0];
                REG_STOP_BIN:    stop_bin_reg     <= cfg_wdata[IDX_W-1:0];
                REG_LEVEL_OFFS:  level_offset_reg <= cfg_wdata;
                REG_AVG_EN:      avg_en_reg       <= cfg_wdata[0];
                REG_MAX_HOLD_EN: max_hold_en_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // clearing pass
    logic              clear_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clear_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) clear_reg <= 1'b0;
        end
    end

    // input window and credit
    logic [IDX_W-1:0] in_idx;
    logic [VAL_W-1:0] in_val;
    logic [IDX_W-1:0] in_rel;
    logic             in_win;
    logic             s_acc;
    logic             m_acc;
    logic             item_in;
    logic [OFIFO_CNT_W-1:0] inflight_reg;
    logic [OFIFO_CNT_W-1:0] inflight_next;

    assign in_idx  = s_tdata[IDX_W-1:0];
    assign in_val  = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign in_rel  = in_idx - start_bin_reg;
    assign in_win  = (in_idx >= start_bin_reg) && (in_idx <= stop_bin_reg)
                     && ({20'b0, in_idx} < 32'(FFT_BINS));
    assign s_tready = !clear_reg && (inflight_reg < OFIFO_CNT_W'(OFIFO_DEPTH));
    assign s_acc   = s_tvalid && s_tready;
    assign m_acc   = m_tvalid && m_tready;
    assign item_in = s_acc && in_win;

    // out-of-window bins never take a credit
    always_comb begin
        inflight_next = inflight_reg;
        if (item_in) inflight_next = inflight_next + 1'b1;
        if (m_acc)   inflight_next = inflight_next - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) inflight_reg <= '0;
        else          inflight_reg <= inflight_next;
    end

    // level pipeline
    logic [7:1]        vld_reg;
    logic [ADDR_W-1:0] rel_reg [1:7];
    logic [VAL_W-1:0]  raw1_reg;
    logic [VAL_W-1:0]  mag2_reg;
    logic [VAL_W-1:0]  norm3_reg;
    logic              hi3_reg;
    logic              zero3_reg, zero4_reg, zero5_reg, zero6_reg;
    logic [4:0]        p4_reg;
    logic [7:0]        f4_reg;
    logic [12:0]       lg5_reg;
    logic [29:0]       prod6_reg;
    logic signed [LVL_W-1:0] lvl7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else          vld_reg <= {vld_reg[6:1], item_in};
    end

    always_ff @(posedge aclk) begin
        rel_reg[1] <= in_rel[ADDR_W-1:0];
        for (int i = 2; i <= 7; i++) rel_reg[i] <= rel_reg[i-1];
    end

    // stage 2: magnitude, the most negative value maps to 2^23
    logic [VAL_W-1:0] mag_c;
    assign mag_c = raw1_reg[VAL_W-1] ? (~raw1_reg + 1'b1) : raw1_reg;

    // stage 3: coarse normalize by twelve
    logic hi_c;
    assign hi_c = |mag2_reg[23:12];

    // stage 4: leading one in the upper half of the normalized word
    logic [3:0]       q_c;
    logic [VAL_W-1:0] fsh_c;
    always_comb begin
        q_c = '0;
        for (int i = 0; i < 12; i++) begin
            if (norm3_reg[12+i]) q_c = 4'(i);
        end
    end
    assign fsh_c = norm3_reg >> (5'(q_c) + 5'd4);

    // stage 7: round, offset, saturate
    logic [30:0]              rnd_c;
    logic signed [16:0]       pre_c;
    logic signed [16:0]       lsum_c;
    assign rnd_c  = {1'b0, prod6_reg} + 31'd32768;
    assign pre_c  = zero6_reg ? 17'(LEVEL_MIN) : $signed({2'b0, rnd_c[30:16]});
    assign lsum_c = pre_c + 17'(level_offset_reg);

    always_ff @(posedge aclk) begin
        raw1_reg  <= in_val;
        mag2_reg  <= mag_c;
        norm3_reg <= hi_c ? mag2_reg : (mag2_reg << 12);
        hi3_reg   <= hi_c;
        zero3_reg <= (mag2_reg == '0);
        p4_reg    <= hi3_reg ? (5'(q_c) + 5'd12) : 5'(q_c);
        f4_reg    <= fsh_c[7:0];
        zero4_reg <= zero3_reg;
        lg5_reg   <= {p4_reg, 8'b0} + 13'(FLOG_TAB[f4_reg]);
        zero5_reg <= zero4_reg;
        prod6_reg <= 30'(lg5_reg) * 30'(LOG_SCALE);
        zero6_reg <= zero5_reg;
        lvl7_reg  <= sat16(lsum_c);
    end

    // trace and peak memories
    logic signed [LVL_W-1:0] trace_mem [DEPTH];
    logic signed [LVL_W-1:0] peak_mem  [DEPTH];
    logic signed [LVL_W-1:0] tr_rd_reg;
    logic signed [LVL_W-1:0] pk_rd_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic signed [LVL_W-1:0] mem_wtr;
    logic signed [LVL_W-1:0] mem_wpk;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            trace_mem[mem_wa] <= mem_wtr;
            peak_mem[mem_wa]  <= mem_wpk;
        end
        tr_rd_reg <= trace_mem[rel_reg[6]];
        pk_rd_reg <= peak_mem[rel_reg[6]];
    end

    // read-modify-write, bypassing the write of the previous cycle
    logic                    wb_vld_reg;
    logic [ADDR_W-1:0]       wb_addr_reg;
    logic signed [LVL_W-1:0] wb_tr_reg;
    logic signed [LVL_W-1:0] wb_pk_reg;
    logic                    fwd_hit;
    logic signed [LVL_W-1:0] old_tr, old_pk;
    logic signed [16:0]      diff_c;
    logic signed [31:0]      dmul_c;
    logic signed [31:0]      dsum_c;
    logic signed [16:0]      avg_c;
    logic signed [LVL_W-1:0] new_tr, new_pk;

    assign fwd_hit = wb_vld_reg && (wb_addr_reg == rel_reg[7]);
    assign old_tr  = fwd_hit ? wb_tr_reg : tr_rd_reg;
    assign old_pk  = fwd_hit ? wb_pk_reg : pk_rd_reg;
    assign diff_c  = 17'(lvl7_reg) - 17'(old_tr);
    assign dmul_c  = 32'(diff_c) * AVG_WEIGHT;
    assign dsum_c  = dmul_c + AVG_ROUND;
    // upper half of the sum is the step rounded to nearest, halves up, sign-extended
    assign avg_c   = 17'(old_tr) + 17'($signed(dsum_c[31:16]));
    assign new_tr  = avg_en_reg ? sat16(avg_c) : lvl7_reg;
    assign new_pk  = (max_hold_en_reg && (new_tr > old_pk)) ? new_tr : old_pk;

    assign mem_we  = clear_reg || vld_reg[7];
    assign mem_wa  = clear_reg ? clr_addr_reg : rel_reg[7];
    assign mem_wtr = clear_reg ? TRACE_RESET : new_tr;
    assign mem_wpk = clear_reg ? LEVEL_MIN : new_pk;

    always_ff @(posedge aclk) begin
        if (!aresetn) wb_vld_reg <= 1'b0;
        else          wb_vld_reg <= vld_reg[7];
        wb_addr_reg <= rel_reg[7];
        wb_tr_reg   <= new_tr;
        wb_pk_reg   <= new_pk;
    end

    // output queue, sized to the credit limit
    res_t                   ofifo_mem [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] wr_ptr_reg;
    logic [OFIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OFIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [OFIFO_CNT_W-1:0] fifo_cnt_next;
    res_t                   res_c;

    assign res_c.trace_index = IDX_W'(rel_reg[7]);
    assign res_c.trace_level = new_tr;
    assign res_c.peak_level  = new_pk;

    always_ff @(posedge aclk) begin
        if (vld_reg[7]) ofifo_mem[wr_ptr_reg] <= res_c;
    end

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (vld_reg[7]) fifo_cnt_next = fifo_cnt_next + 1'b1;
        if (m_acc)      fifo_cnt_next = fifo_cnt_next - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (vld_reg[7]) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (m_acc)      rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {4'b0, ofifo_mem[rd_ptr_reg]};

    // checks
    `STAMH_ASSERT_ALWAYS(a_credit_bound, inflight_reg <= OFIFO_CNT_W'(OFIFO_DEPTH), "credit overrun")
    `STAMH_ASSERT_ALWAYS(a_queue_within_credit, fifo_cnt_reg <= inflight_reg, "queue over credit")
    `STAMH_ASSERT_IMPLY(a_no_item_in_clear, clear_reg, !vld_reg[7], "item write during clear")

endmodule
